FILE: src/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg
// shared widths, command codes and datapath tag type of the matrix multiplier
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

    localparam int DIM_DEFAULT = 8;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 3;
    localparam int VALUE_W = 16;
    localparam int PROD_W  = 38;

    localparam int IN_DATA_W  = CMD_W + 2 * IDX_W + VALUE_W;
    localparam int OUT_USED_W = 2 * IDX_W + PROD_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_WR_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ROW  = 2'd2;

    // travels beside each multiply-accumulate operand pair
    typedef struct packed {
        logic valid;
        logic last;
    } t_mac_tag;

endpackage

`default_nettype wire

FILE: src/square_matrix_multiply.sv
// ----------------------------------------------------------------------------
// square_matrix_multiply
// DIM x DIM signed matrix product, one product row per compute command
// ----------------------------------------------------------------------------
// Write commands (cmd 0 for A, cmd 1 for B) store one 16-bit element. A
// compute command (cmd 2) streams the DIM elements of one product row in
// column order, the last one flagged on tlast; it runs DIM*DIM
// multiply-accumulate steps through a single shared multiplier fed from the
// two element memories, one step per cycle while the output side keeps up,
// through read, multiply and accumulate stages. Output stalls hold the whole
// datapath. No new command is taken while a row is being computed; one is
// taken while the final result still waits on the output. Writes with a row
// or column index not below DIM, computes with a row index not below DIM,
// and cmd 3, are dropped without a result. Elements read before they were
// ever written return unspecified values.
// ----------------------------------------------------------------------------
`default_nettype none

module square_matrix_multiply
    import smm_pkg::*;
#(
    parameter int DIM = DIM_DEFAULT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // cmd[1:0], row[4:2], col[7:5], value[23:8]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // out_row[2:0], out_col[5:3], product[43:6], zero fill[47:44]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast
);

    localparam int DEPTH  = DIM * DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int K_W    = (DIM > 1) ? $clog2(DIM) : 1;

    // input fields
    logic [CMD_W-1:0]          in_cmd;
    logic [IDX_W-1:0]          in_row;
    logic [IDX_W-1:0]          in_col;
    logic signed [VALUE_W-1:0] in_value;
    logic                      in_acc;
    logic                      row_ok;
    logic                      col_ok;
    logic [ADDR_W-1:0]         wr_addr;

    // sequencer
    logic             r_issue;
    logic [IDX_W-1:0] r_row;
    logic [K_W-1:0]   r_j;
    logic [K_W-1:0]   r_k;
    logic             k_end;
    logic             j_end;
    logic             adv;

    // memories and read stage
    logic signed [VALUE_W-1:0] r_mem_a [DEPTH];
    logic signed [VALUE_W-1:0] r_mem_b [DEPTH];
    logic signed [VALUE_W-1:0] r_a_q;
    logic signed [VALUE_W-1:0] r_b_q;
    logic [ADDR_W-1:0]         rd_addr_a;
    logic [ADDR_W-1:0]         rd_addr_b;
    t_mac_tag                  r_rd_tag;
    t_mac_tag                  rd_tag_n;
    logic [K_W-1:0]            r_rd_col;
    logic [K_W-1:0]            r_mul_col;

    // accumulator side
    t_mac_tag                  mac_tag;
    logic signed [PROD_W-1:0]  mac_sum;
    logic                      elem_done;

    // output register
    logic                      r_out_v;
    logic [IDX_W-1:0]          r_out_row;
    logic [IDX_W-1:0]          r_out_col;
    logic signed [PROD_W-1:0]  r_out_prod;
    logic                      r_out_last;

    assign in_cmd   = s_axis_tdata[CMD_W-1:0];
    assign in_row   = s_axis_tdata[CMD_W +: IDX_W];
    assign in_col   = s_axis_tdata[CMD_W+IDX_W +: IDX_W];
    assign in_value = s_axis_tdata[CMD_W+2*IDX_W +: VALUE_W];

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign row_ok  = 32'(in_row) < 32'(DIM);
    assign col_ok  = 32'(in_col) < 32'(DIM);
    assign wr_addr = ADDR_W'(32'(in_row) * 32'(DIM) + 32'(in_col));

    // whole datapath moves only when the output register can take a result
    assign adv = !r_out_v || m_axis_tready;

    assign s_axis_tready = !r_issue && !r_rd_tag.valid && !mac_tag.valid;

    assign k_end = r_k == K_W'(DIM - 1);
    assign j_end = r_j == K_W'(DIM - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_j     <= '0;
            r_k     <= '0;
        end else if (in_acc) begin
            if (in_cmd == CMD_ROW && row_ok) begin
                r_issue <= 1'b1;
                r_j     <= '0;
                r_k     <= '0;
            end
        end else if (adv && r_issue) begin
            if (k_end) begin
                r_k <= '0;
                if (j_end) begin
                    r_issue <= 1'b0;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_cmd == CMD_ROW) begin
            r_row <= in_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && row_ok && col_ok) begin
            if (in_cmd == CMD_WR_A) begin
                r_mem_a[wr_addr] <= in_value;
            end
            if (in_cmd == CMD_WR_B) begin
                r_mem_b[wr_addr] <= in_value;
            end
        end
    end

    // A row-major along k, B down column j
    assign rd_addr_a = ADDR_W'(32'(r_row) * 32'(DIM) + 32'(r_k));
    assign rd_addr_b = ADDR_W'(32'(r_k) * 32'(DIM) + 32'(r_j));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_q <= r_mem_a[rd_addr_a];
            r_b_q <= r_mem_b[rd_addr_b];
        end
    end

    always_comb begin
        rd_tag_n.valid = r_issue;
        rd_tag_n.last  = k_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_tag <= '0;
        end else if (adv) begin
            r_rd_tag <= rd_tag_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd_col  <= r_j;
            r_mul_col <= r_rd_col;
        end
    end

    smm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_tag   (r_rd_tag),
        .i_a     (r_a_q),
        .i_b     (r_b_q),
        .o_tag   (mac_tag),
        .o_sum   (mac_sum)
    );

    assign elem_done = adv && mac_tag.valid && mac_tag.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (elem_done) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    // row is held with the item, a new command may arrive while it waits
    always_ff @(posedge i_clk) begin
        if (elem_done) begin
            r_out_row  <= r_row;
            r_out_col  <= IDX_W'(r_mul_col);
            r_out_prod <= mac_sum;
            r_out_last <= r_mul_col == K_W'(DIM - 1);
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), r_out_prod, r_out_col, r_out_row};

endmodule

`default_nettype wire

FILE: src/smm_mac.sv
// ----------------------------------------------------------------------------
// smm_mac
// shared signed multiplier and accumulator, one operand pair per cycle while i_adv is high
// ----------------------------------------------------------------------------
`default_nettype none

module smm_mac
    import smm_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire t_mac_tag                  i_tag,
    input  wire logic signed [VALUE_W-1:0] i_a,
    input  wire logic signed [VALUE_W-1:0] i_b,
    output t_mac_tag                       o_tag,
    output logic signed [PROD_W-1:0]       o_sum
);

    localparam int MUL_W = 2 * VALUE_W;

    logic signed [MUL_W-1:0]  r_mul;
    t_mac_tag                 r_tag;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [PROD_W-1:0] mul_ext;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mul <= i_a * i_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
            r_acc <= '0;
        end else if (i_adv) begin
            r_tag <= i_tag;
            if (r_tag.valid) begin
                // restart the sum after the final term of an element
                r_acc <= r_tag.last ? '0 : o_sum;
            end
        end
    end

    assign mul_ext = {{(PROD_W - MUL_W){r_mul[MUL_W-1]}}, r_mul};
    assign o_sum   = r_acc + mul_ext;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

FILE: src/smm_checker.sv
// ----------------------------------------------------------------------------
// smm_checker
// port-level checks of the matrix multiplier, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module smm_checker
    import smm_pkg::*;
#(
    parameter int DIM = DIM_DEFAULT
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                  m_axis_tlast
);

    logic in_acc;
    logic is_write;
    logic is_row;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign is_write = s_axis_tdata[CMD_W-1:0] == CMD_WR_A
                   || s_axis_tdata[CMD_W-1:0] == CMD_WR_B;
    assign is_row   = s_axis_tdata[CMD_W-1:0] == CMD_ROW
                   && 32'(s_axis_tdata[CMD_W +: IDX_W]) < 32'(DIM);

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    // the input stays ready after an element write
    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && is_write |=> s_axis_tready)
        else $error("not ready after element write");

    // a valid compute command closes the input once it is taken
    a_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && is_row |=> !s_axis_tready)
        else $error("input open right after compute command");

    // the flagged item is the final column of the row
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[IDX_W +: IDX_W] == IDX_W'(DIM - 1))
        else $error("last flag on wrong column");

endmodule

bind square_matrix_multiply smm_checker #(.DIM(DIM)) u_smm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: bench/square_matrix_multiply_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// square_matrix_multiply_tb
// self-checking bench for the 8 x 8 signed matrix multiplier
// ----------------------------------------------------------------------------
// Rows 0 and 7 of A and every element of B are loaded before the first row
// is computed, and only those two product rows are ever computed. Next come
// directed rows built from the extreme element values, then a random mix of
// element writes, row computes and unused commands. A local copy of both
// matrices predicts every product element. Each output item is checked
// field by field against the oldest predicted element. Random gaps on the
// input side and random stalls on the output side are on most of the time,
// with some stretches run at full rate.
// ----------------------------------------------------------------------------

module square_matrix_multiply_tb;
    import smm_pkg::*;

    localparam int                 MAT_DIM    = 8;
    localparam int                 CYCLE_MAX  = 600_000;
    localparam int                 REPORT_MAX = 10;
    localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
    localparam logic [IDX_W-1:0]   ROW_LO     = 3'd0;
    localparam logic [IDX_W-1:0]   ROW_HI     = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [PROD_W-1:0] product;
        logic                     last;
    } t_product_elem;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // cmd[1:0], row[4:2], col[7:5], value[23:8]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // out_row[2:0], out_col[5:3], product[43:6], zero fill[47:44]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    logic signed [VALUE_W-1:0] matrix_a_copy [MAT_DIM][MAT_DIM];
    logic signed [VALUE_W-1:0] matrix_b_copy [MAT_DIM][MAT_DIM];
    t_product_elem             pending_products [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  stall_left     = 0;
    bit  idle_on        = 1'b1;

    square_matrix_multiply #(
        .DIM(MAT_DIM)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("square_matrix_multiply: mismatch");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // only rows whose A elements are all loaded
    function automatic logic [IDX_W-1:0] pick_row();
        return ($urandom_range(0, 1) == 0) ? ROW_LO : ROW_HI;
    endfunction

    // exact row of A*B, kept in order of emission
    function automatic void predict_product_row(input logic [IDX_W-1:0] r);
        longint        acc;
        t_product_elem elem;
        for (int j = 0; j < MAT_DIM; j++) begin
            acc = 0;
            for (int k = 0; k < MAT_DIM; k++)
                acc += longint'(matrix_a_copy[r][k]) * longint'(matrix_b_copy[k][j]);
            elem.row     = r;
            elem.col     = IDX_W'(j);
            elem.product = acc[PROD_W-1:0];
            elem.last    = (j == MAT_DIM - 1);
            pending_products.push_back(elem);
        end
    endfunction

    function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                          input logic [IDX_W-1:0] r,
                                          input logic [IDX_W-1:0] c,
                                          input logic signed [VALUE_W-1:0] v);
        case (cmd)
            CMD_WR_A: matrix_a_copy[r][c] = v;
            CMD_WR_B: matrix_b_copy[r][c] = v;
            CMD_ROW:  predict_product_row(r);
            default: ;
        endcase
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c,
                             input logic signed [VALUE_W-1:0] v);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, c, r, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        apply_command(cmd, r, c, v);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge i_clk);
    endtask

    // output side: random stalls while idling is on
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall_left    <= pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input longint exp_v,
                                   input longint got_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0d: %s expected %0d got %0d", cycle_count, what, exp_v, got_v);
    endtask

    always @(posedge i_clk) begin
        t_product_elem            want;
        logic signed [PROD_W-1:0] got_product;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_products.size() == 0) begin
                report_mismatch("unexpected item, row", -1, longint'(m_axis_tdata[2:0]));
            end else begin
                want        = pending_products.pop_front();
                got_product = m_axis_tdata[43:6];
                if (m_axis_tdata[2:0] != want.row)
                    report_mismatch("out_row", longint'(want.row),
                                    longint'(m_axis_tdata[2:0]));
                if (m_axis_tdata[5:3] != want.col)
                    report_mismatch("out_col", longint'(want.col),
                                    longint'(m_axis_tdata[5:3]));
                if (got_product !== want.product)
                    report_mismatch("product", longint'(want.product),
                                    longint'(got_product));
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", longint'(want.last), longint'(m_axis_tlast));
            end
        end
    end

    // every element that a computed row reads is written before any row is read
    task automatic test_fill_matrices();
        for (int c = 0; c < MAT_DIM; c++) begin
            send_item(CMD_WR_A, ROW_LO, IDX_W'(c), pick_value());
            send_item(CMD_WR_A, ROW_HI, IDX_W'(c), pick_value());
        end
        for (int r = 0; r < MAT_DIM; r++)
            for (int c = 0; c < MAT_DIM; c++)
                send_item(CMD_WR_B, IDX_W'(r), IDX_W'(c), pick_value());
    endtask

    task automatic test_extreme_products();
        // most negative row times most negative column gives the largest sum
        for (int k = 0; k < MAT_DIM; k++)
            send_item(CMD_WR_A, 3'd7, IDX_W'(k), 16'sh8000);
        for (int k = 0; k < MAT_DIM; k++)
            send_item(CMD_WR_B, IDX_W'(k), 3'd7, 16'sh8000);
        send_item(CMD_ROW, 3'd7, 3'd0, 16'sh0000);
        send_item(CMD_WR_A, 3'd7, 3'd0, 16'sh7fff);
        send_item(CMD_ROW, 3'd7, 3'd7, -16'sd1);
        send_item(CMD_UNUSED, 3'd7, 3'd7, -16'sd1);
        send_item(CMD_ROW, 3'd0, 3'd5, 16'sh5a5a);
    endtask

    task automatic test_random_mix();
        int sel;
        for (int i = 0; i < 16; i++) begin
            idle_on = (i % 8) >= 3;
            sel     = $urandom_range(0, 9);
            if (sel < 3)
                send_item(CMD_WR_A, IDX_W'($urandom), IDX_W'($urandom), pick_value());
            else if (sel < 6)
                send_item(CMD_WR_B, IDX_W'($urandom), IDX_W'($urandom), pick_value());
            else if (sel < 9)
                send_item(CMD_ROW, pick_row(), IDX_W'($urandom), VALUE_W'($urandom));
            else
                send_item(CMD_UNUSED, IDX_W'($urandom), IDX_W'($urandom),
                          VALUE_W'($urandom));
        end
        idle_on = 1'b1;
    endtask

    task automatic test_pause_for_drain();
        send_item(CMD_ROW, pick_row(), IDX_W'($urandom), VALUE_W'($urandom));
        wait_for_drain();
        send_item(CMD_WR_A, IDX_W'($urandom), IDX_W'($urandom), pick_value());
        send_item(CMD_ROW, pick_row(), IDX_W'($urandom), VALUE_W'($urandom));
        send_item(CMD_ROW, pick_row(), IDX_W'($urandom), VALUE_W'($urandom));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_matrices();
        test_extreme_products();
        test_random_mix();
        test_pause_for_drain();

        wait_for_drain();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && pending_products.size() == 0)
            $display("square_matrix_multiply: match");
        else
            $display("square_matrix_multiply: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
src/smm_pkg.sv
src/smm_mac.sv
src/square_matrix_multiply.sv
src/smm_checker.sv
bench/square_matrix_multiply_tb.sv
